// File: rtl/cdc_pkg.sv
package cdc_pkg;

  localparam int ANGLE_W    = 24;
  localparam int TIME_W     = 32;
  localparam int DEG_W      = 32;
  localparam int TPT_W      = 16;
  localparam int TEETH_W    = 8;
  localparam int SUM_W      = TEETH_W + 1;
  localparam int TPD_PROD_W = TPT_W + SUM_W;
  localparam int TPD_W      = 17;
  localparam int RECIP_W    = 33;
  localparam int CNT_W      = $clog2(RECIP_W + 1);
  localparam int ET_W       = 23;
  localparam int EC_W       = 7;
  localparam int CYC_IN_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIV360_M_W  = 26;
  localparam int DIV360_SH   = 34;
  localparam int DIV1000_M_W = 29;
  localparam int DIV1000_SH  = 38;
  localparam int DIV720_M_W  = 16;
  localparam int DIV720_SH   = 25;

  localparam int SCALE_W = TPD_PROD_W + DIV360_M_W;
  localparam int PDEG_W  = ANGLE_W + RECIP_W;
  localparam int PTIME_W = TIME_W + DIV1000_M_W;
  localparam int PBACK_W = ANGLE_W + TPD_W;
  localparam int PCYC_W  = CYC_IN_W + DIV720_M_W;

  localparam logic [DIV360_M_W-1:0]  DIV360_M  = 26'd47721859;
  localparam logic [DIV1000_M_W-1:0] DIV1000_M = 29'd274877907;
  localparam logic [DIV720_M_W-1:0]  DIV720_M  = 16'd46604;

  localparam logic [ET_W-1:0]    TIMER_CAP = 23'd10000;
  localparam logic [EC_W-1:0]    CYCLES_MAX = 7'd91;
  localparam logic [RECIP_W-1:0] RECIP_NUM = {1'b1, {(RECIP_W-1){1'b0}}};

  localparam logic [TPT_W-1:0]   TPT_RESET    = 16'd1024;
  localparam logic [TEETH_W-1:0] PRESENT_RESET = 8'd35;
  localparam logic [TEETH_W-1:0] ABSENT_RESET  = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOOTH_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_TEETH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_TEETH  = 2'd2;

  typedef struct packed {
    logic               in_full_sync;
    logic [ANGLE_W-1:0] angle_count;
    logic [TIME_W-1:0]  time_now;
  } item_t;

  typedef struct packed {
    logic [DEG_W-1:0]   degree_total;
    logic [ANGLE_W-1:0] degrees_advanced;
    logic               restarted;
    logic [ET_W-1:0]    time_since_start;
    logic [EC_W-1:0]    cycles_since_start;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CFG_MUL,
    ST_CFG_SCALE,
    ST_CFG_START,
    ST_CFG_DIV,
    ST_MUL,
    ST_STEP,
    ST_UPDATE,
    ST_CYCLES,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic cfg_prod;
    logic cfg_scale;
    logic div_start;
    logic mul;
    logic back;
    logic update;
    logic cycles;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_written;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/cdc_recip.sv
module cdc_recip import cdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TPD_W-1:0]   divisor,
  output logic               busy,
  output logic [RECIP_W-1:0] quotient
);

  logic [CNT_W-1:0]   cnt;
  logic [TPD_W-1:0]   rem;
  logic [RECIP_W-1:0] num;
  logic [TPD_W:0]     trial;
  logic [TPD_W:0]     diff;
  logic               fits;

  // Restoring division, one quotient bit per cycle; quotient bits shift into num.
  assign trial = {rem, num[RECIP_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(RECIP_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= RECIP_NUM;
    end else if (cnt != '0) begin
      rem <= fits ? diff[TPD_W-1:0] : trial[TPD_W-1:0];
      num <= {num[RECIP_W-2:0], fits};
    end
  end

  assign busy     = cnt != '0;
  assign quotient = num;

endmodule

// File: rtl/cdc_ctrl.sv
module cdc_ctrl import cdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic        dirty, dirty_next;
  logic        ready;

  assign ready = (state == ST_IDLE) && !dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dirty <= 1'b1;
    end else begin
      state <= state_next;
      dirty <= dirty_next;
    end
  end

  always_comb begin
    dirty_next = status.cfg_written || (dirty && (state != ST_CFG_MUL));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (dirty) begin
          state_next = ST_CFG_MUL;
        end else if (item_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_CFG_MUL:   state_next = ST_CFG_SCALE;
      ST_CFG_SCALE: state_next = ST_CFG_START;
      ST_CFG_START: state_next = ST_CFG_DIV;
      ST_CFG_DIV: begin
        if (!status.div_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL:    state_next = ST_STEP;
      ST_STEP:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_CYCLES;
      ST_CYCLES: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = !ready;
    case (state)
      ST_IDLE:      cmd.load_item = ready && item_valid;
      ST_CFG_MUL:   cmd.cfg_prod = 1'b1;
      ST_CFG_SCALE: cmd.cfg_scale = 1'b1;
      ST_CFG_START: cmd.div_start = 1'b1;
      ST_CFG_DIV:   cmd = '0;
      ST_MUL:       cmd.mul = 1'b1;
      ST_STEP:      cmd.back = 1'b1;
      ST_UPDATE:    cmd.update = 1'b1;
      ST_CYCLES:    cmd.cycles = 1'b1;
      ST_DONE:      cmd.finish = status.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// File: rtl/cdc_datapath.sv
module cdc_datapath import cdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  item_t                 item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  logic [TPT_W-1:0]      tooth_ticks;
  logic [TEETH_W-1:0]    present_teeth;
  logic [TEETH_W-1:0]    absent_teeth;
  logic [TPD_PROD_W-1:0] tpd_prod;
  logic [TPD_W-1:0]      tpd;
  logic [RECIP_W-1:0]    recip;
  logic                  div_busy;

  logic [ANGLE_W-1:0] angle;
  logic [TIME_W-1:0]  now;
  logic               restart;

  logic [ANGLE_W-1:0] last_angle;
  logic [DEG_W-1:0]   degree_count;
  logic [TIME_W-1:0]  sync_stamp;
  logic               was_synced;
  logic [ET_W-1:0]    elapsed_time;

  logic [PDEG_W-1:0]  p_deg;
  logic [PTIME_W-1:0] p_time;
  logic [ANGLE_W-1:0] p_back;
  logic [PCYC_W-1:0]  p_cyc;

  logic [SUM_W-1:0]      teeth_sum;
  logic [TPD_PROD_W-1:0] prod_w;
  logic [SCALE_W-1:0]    scale_w;
  logic [TPD_W-1:0]      tpd_w;
  logic [ANGLE_W-1:0]    delta;
  logic [TIME_W-1:0]     time_diff;
  logic [PDEG_W-1:0]     p_deg_w;
  logic [PTIME_W-1:0]    p_time_w;
  logic [ANGLE_W-1:0]    deg;
  logic [PBACK_W-1:0]    p_back_w;
  logic [PCYC_W-1:0]     p_cyc_w;
  logic                  item_restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      tooth_ticks   <= TPT_RESET;
      present_teeth <= PRESENT_RESET;
      absent_teeth  <= ABSENT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOOTH_TICKS:   tooth_ticks <= cfg_data;
        CFG_PRESENT_TEETH: present_teeth <= cfg_data[TEETH_W-1:0];
        CFG_ABSENT_TEETH:  absent_teeth <= cfg_data[TEETH_W-1:0];
        default: ;
      endcase
    end
  end

  assign teeth_sum = {1'b0, present_teeth} + {1'b0, absent_teeth};
  assign prod_w    = tooth_ticks * teeth_sum;
  assign scale_w   = tpd_prod * DIV360_M;
  assign tpd_w     = scale_w[DIV360_SH +: TPD_W];

  always_ff @(posedge clk) begin
    if (cmd.cfg_prod) begin
      tpd_prod <= prod_w;
    end
    if (cmd.cfg_scale) begin
      tpd <= (tpd_w == '0) ? TPD_W'(1) : tpd_w;
    end
  end

  cdc_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  (tpd),
    .busy     (div_busy),
    .quotient (recip)
  );

  assign item_restart = !item.in_full_sync || !was_synced;

  assign delta     = angle - last_angle;
  assign time_diff = now - sync_stamp;
  assign p_deg_w   = delta * recip;
  assign p_time_w  = time_diff * DIV1000_M;
  assign deg       = p_deg[32 +: ANGLE_W];
  assign p_back_w  = deg * tpd;
  assign p_cyc_w   = degree_count[CYC_IN_W-1:0] * DIV720_M;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      angle   <= item.angle_count;
      now     <= item.time_now;
      restart <= item_restart;
    end
    if (cmd.mul) begin
      p_deg  <= p_deg_w;
      p_time <= p_time_w;
    end
    if (cmd.back) begin
      p_back <= p_back_w[ANGLE_W-1:0];
    end
    if (cmd.cycles) begin
      p_cyc <= p_cyc_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle   <= '0;
      degree_count <= '0;
      sync_stamp   <= '0;
      was_synced   <= 1'b0;
      elapsed_time <= '0;
    end else if (cmd.load_item && item_restart) begin
      last_angle   <= item.angle_count;
      degree_count <= '0;
      sync_stamp   <= item.time_now;
      was_synced   <= item.in_full_sync;
      elapsed_time <= '0;
    end else if (cmd.update) begin
      last_angle   <= last_angle + p_back;
      degree_count <= degree_count + DEG_W'(deg);
      if (elapsed_time < TIMER_CAP) begin
        elapsed_time <= p_time[DIV1000_SH +: ET_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.degree_total       <= degree_count;
      result.degrees_advanced   <= deg;
      result.restarted          <= restart;
      result.time_since_start   <= elapsed_time;
      result.cycles_since_start <= p_cyc[DIV720_SH +: EC_W];
    end
  end

  assign status.cfg_written = cfg_we;
  assign status.div_busy    = div_busy;
  assign status.out_free    = !result_valid || !result_stall;

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_valid)
    else $error("Result register not loaded after finish.");

  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && restart) |=>
      (result.degree_total == '0 && result.degrees_advanced == '0 &&
       result.time_since_start == '0 && result.cycles_since_start == '0))
    else $error("Restart item produced a nonzero result.");

  a_tpd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.cfg_scale |=> tpd != '0)
    else $error("Ticks per degree left at zero.");

  a_cycles_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.cycles_since_start <= CYCLES_MAX)
    else $error("Cycle count out of range.");

endmodule

// File: rtl/crank_degree_clock_core.sv
// Crank degree clock. Each input item carries the full-sync flag, the
// free-running angle tick counter and the system time; each item yields
// exactly one result item with the degree clock, the degrees added, the
// restart flag and the two post-start timers.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. Configuration registers are written through cfg_we,
// cfg_index and cfg_data, one register per cycle, with no read-back.
// A result is presented once its item has passed through the states MUL,
// STEP, UPDATE, CYCLES and DONE; the next item is accepted only once the
// previous one has loaded its result. These states form the chain of
// registered multiplies: delta times reciprocal, degrees times ticks per
// degree, and the constant divisions by 1000 and 720.
// After reset, and after any configuration write, the block computes ticks
// per degree and its reciprocal with a one-bit-per-cycle divider; input
// stall stays high while this runs.
// When the receiver stalls, the result is held in the output register; the
// block still accepts and works on the next item, and waits only at the
// point of loading its result until the register is free.
module crank_degree_clock_core import cdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cdc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  cdc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
